// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the volatility block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RWV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/rwv_pkg.sv -----
// ----------------------------------------------------------------------------
// rwv_pkg
// Types and fixed constants shared by the rolling volatility modules.
// ----------------------------------------------------------------------------
package rwv_pkg;

  localparam int unsigned VOL_W     = 27;
  localparam int unsigned USED_W    = 9;
  localparam int unsigned WIN_CFG_W = 9;
  localparam int unsigned PPY_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [VOL_W-1:0]     VOL_MAX     = {VOL_W{1'b1}};
  localparam logic [WIN_CFG_W-1:0] WIN_RESET   = 9'd20;
  localparam logic [PPY_W-1:0]     PPY_RESET   = 10'd252;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPY    = 1'b1;

  typedef struct packed {
    logic take;
    logic acc_clear;
    logic rd_issue;
    logic mul_sq_load;
    logic mul_neg_load;
    logic mul_ppy_load;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic rd_last;
    logic pipe_busy;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hdl/rwv_ctrl.sv -----
// ----------------------------------------------------------------------------
// rwv_ctrl
// Sequencer for one item: ring scan, serial products, division, root.
// ----------------------------------------------------------------------------
module rwv_ctrl #(
  parameter int unsigned DIV_W = 76
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rwv_pkg::dp_status_t  status_i,
  output rwv_pkg::dp_cmd_t     cmd_o
);

  localparam int unsigned CTR_W = $clog2(DIV_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_MN    = 4'd5;
  localparam logic [3:0] S_PPY   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_SQL   = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CTR_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (status_i.n_small) begin
          state_d = S_FIN;
        end else begin
          cmd_o.acc_clear = 1'b1;
          state_d         = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.rd_issue = 1'b1;
        if (status_i.rd_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.mul_sq_load = 1'b1;
          state_d           = S_SQ;
        end
      end
      S_SQ: begin
        if (status_i.mul_done) begin
          cmd_o.mul_neg_load = 1'b1;
          state_d            = S_MN;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_MN: begin
        if (status_i.mul_done) begin
          cmd_o.mul_ppy_load = 1'b1;
          state_d            = S_PPY;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_PPY: begin
        if (status_i.mul_done) begin
          cmd_o.div_load = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CTR_W'(DIV_W - 1)) begin
          state_d = S_SQL;
        end
      end
      S_SQL: begin
        cmd_o.sqrt_load = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CTR_W'(rwv_pkg::VOL_W - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hdl/rwv_datapath.sv -----
// ----------------------------------------------------------------------------
// rwv_datapath
// Sample ring, window sums, shift-add multiplier, restoring divider,
// digit-by-digit square root, configuration and output registers.
// ----------------------------------------------------------------------------
module rwv_datapath #(
  parameter int unsigned WINDOW_MAX  = 256,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned DIV_W       = 76
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rwv_pkg::dp_cmd_t                    cmd_i,
  output rwv_pkg::dp_status_t                 status_o,
  input  logic                                cfg_valid_i,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rwv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value_i,
  input  logic                                start_series_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rwv_pkg::VOL_W-1:0]           volatility_o,
  output logic                                valid_res_o,
  output logic [rwv_pkg::USED_W-1:0]          samples_used_o
);

  localparam int unsigned VW     = rwv_pkg::VOL_W;
  localparam int unsigned PTR_W  = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LIM_W  = (CNT_W > rwv_pkg::WIN_CFG_W) ? CNT_W : rwv_pkg::WIN_CFG_W;
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ1_W  = 2 * SAMPLE_BITS;
  localparam int unsigned SQS_W  = 2 * SAMPLE_BITS + CNT_W;
  localparam int unsigned PROD_W = SQS_W + CNT_W + rwv_pkg::PPY_W;
  localparam int unsigned DEN_W  = 2 * CNT_W;
  localparam int unsigned SR_W   = VW + 3;

  // Configuration registers.
  logic [rwv_pkg::WIN_CFG_W-1:0] win_cfg_q;
  logic [rwv_pkg::PPY_W-1:0]     ppy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= rwv_pkg::WIN_RESET;
      ppy_q     <= rwv_pkg::PPY_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rwv_pkg::CFG_IDX_WINDOW: win_cfg_q <= cfg_data_i[rwv_pkg::WIN_CFG_W-1:0];
        rwv_pkg::CFG_IDX_PPY:    ppy_q     <= cfg_data_i[rwv_pkg::PPY_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring bookkeeping and window size.
  logic [PTR_W-1:0] wr_pos_q, wr_idx, wr_next;
  logic [CNT_W-1:0] fill_q, fill_next, n_q, n_next;
  logic [LIM_W-1:0] win_ext, win_lim;

  always_comb begin
    wr_idx  = start_series_i ? '0 : wr_pos_q;
    wr_next = (wr_idx == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_idx + 1'b1;
    if (start_series_i) begin
      fill_next = CNT_W'(1);
    end else if (fill_q == CNT_W'(WINDOW_MAX)) begin
      fill_next = fill_q;
    end else begin
      fill_next = fill_q + 1'b1;
    end
    win_ext = LIM_W'(win_cfg_q);
    priority if (win_ext < LIM_W'(2)) begin
      win_lim = LIM_W'(2);
    end else if (win_ext > LIM_W'(WINDOW_MAX)) begin
      win_lim = LIM_W'(WINDOW_MAX);
    end else begin
      win_lim = win_ext;
    end
    n_next = (win_lim < LIM_W'(fill_next)) ? CNT_W'(win_lim) : fill_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      fill_q   <= '0;
      n_q      <= '0;
    end else if (cmd_i.take) begin
      wr_pos_q <= wr_next;
      fill_q   <= fill_next;
      n_q      <= n_next;
    end
  end

  // Sample memory: one write per item, one read per cycle during the scan.
  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic [PTR_W-1:0]              rd_ptr_q;
  logic [CNT_W-1:0]              rd_cnt_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ring_mem[wr_idx] <= sample_value_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= ring_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_ptr_q <= '0;
      rd_cnt_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.acc_clear) begin
        // Start from the newest sample and walk backwards.
        rd_ptr_q <= (wr_pos_q == '0) ? PTR_W'(WINDOW_MAX - 1) : wr_pos_q - 1'b1;
        rd_cnt_q <= '0;
      end else if (cmd_i.rd_issue) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_q - 1'b1;
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  // Square stage, then accumulation.
  logic [SAMPLE_BITS-1:0]        rd_u, smag;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [SQ1_W-1:0]              sq_q;
  logic                          sq_vld_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [SQS_W-1:0]              sqs_q;

  assign rd_u = rd_data_q;
  assign smag = rd_data_q[SAMPLE_BITS-1] ? (~rd_u + 1'b1) : rd_u;

  always_ff @(posedge clk_i) begin
    smp_q <= rd_data_q;
    sq_q  <= SQ1_W'(smag) * SQ1_W'(smag);
    if (cmd_i.acc_clear) begin
      sum_q <= '0;
      sqs_q <= '0;
    end else if (sq_vld_q) begin
      sum_q <= sum_q + SUM_W'(smp_q);
      sqs_q <= sqs_q + SQS_W'(sq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= rd_vld_q;
    end
  end

  // Shift-add multiplier. The product n*S2 - S1^2 is built by loading the
  // negated square of the sum into the accumulator before adding n*S2.
  logic [SUM_W-1:0]  sum_u, sum_mag;
  logic [PROD_W-1:0] ma_q, acc_q;
  logic [SUM_W-1:0]  mb_q;

  assign sum_u   = sum_q;
  assign sum_mag = sum_q[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.mul_sq_load) begin
      ma_q  <= PROD_W'(sum_mag);
      mb_q  <= sum_mag;
      acc_q <= '0;
    end else if (cmd_i.mul_neg_load) begin
      ma_q  <= PROD_W'(sqs_q);
      mb_q  <= SUM_W'(n_q);
      acc_q <= ~acc_q + 1'b1;
    end else if (cmd_i.mul_ppy_load) begin
      ma_q  <= acc_q;
      mb_q  <= SUM_W'(ppy_q);
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + ma_q;
      end
      ma_q <= {ma_q[PROD_W-2:0], 1'b0};
      mb_q <= {1'b0, mb_q[SUM_W-1:1]};
    end
  end

  // Restoring divider by n*(n-1); the dividend register later feeds the root.
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             div_ge;
  logic [DIV_W-1:0] dvd_q;

  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign div_ge  = (rem_sh >= {1'b0, den_q});

  // Square root, two radicand bits per step.
  logic [SR_W-1:0] srem_q, sr_r, sr_trial;
  logic [VW-1:0]   root_q;
  logic            sat_q, sr_ge;

  assign sr_r     = {srem_q[SR_W-3:0], dvd_q[2*VW-1:2*VW-2]};
  assign sr_trial = SR_W'({root_q, 2'b01});
  assign sr_ge    = (sr_r >= sr_trial);

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.div_load) begin
      dvd_q <= DIV_W'(acc_q);
      rem_q <= '0;
      den_q <= DEN_W'(n_q) * DEN_W'(n_q - 1'b1);
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
    end else if (cmd_i.sqrt_load) begin
      // Anything at or above 2^(2*VOL_W) has a root beyond the output range.
      sat_q  <= |dvd_q[DIV_W-1:2*VW];
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sr_ge ? (sr_r - sr_trial) : sr_r;
      root_q <= {root_q[VW-2:0], sr_ge};
      dvd_q  <= {dvd_q[DIV_W-3:0], 2'b00};
    end
  end

  // Output register.
  logic                          out_valid_q;
  logic [VW-1:0]                 vol_q;
  logic                          vres_q;
  logic [rwv_pkg::USED_W-1:0]    used_q;
  logic                          n_small;

  assign n_small = (n_q < CNT_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      priority if (n_small) begin
        vol_q <= '0;
      end else if (sat_q) begin
        vol_q <= rwv_pkg::VOL_MAX;
      end else begin
        vol_q <= root_q;
      end
      vres_q <= ~n_small;
      used_q <= rwv_pkg::USED_W'(n_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign volatility_o   = vol_q;
  assign valid_res_o    = vres_q;
  assign samples_used_o = used_q;

  assign status_o.n_small   = n_small;
  assign status_o.rd_last   = (rd_cnt_q == n_q - 1'b1);
  assign status_o.pipe_busy = rd_vld_q | sq_vld_q;
  assign status_o.mul_done  = (mb_q == '0);
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

endmodule

// ----- hdl/rolling_window_volatility.sv -----
// ----------------------------------------------------------------------------
// rolling_window_volatility
// Annualised rolling sample standard deviation of a stream of returns.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item with fewer than two samples held
// goes from the sample check straight to the output register. Otherwise
// the sample ring is scanned through its single read port, a shift-add
// multiplier forms S1^2, n*S2 and the annualising product one bit per
// cycle, a restoring divider spends one cycle per dividend bit (DIV_W, 76
// by default) and the square root resolves one result bit per cycle. A
// finished result waits in the output register while the next item is
// already being accepted.
module rolling_window_volatility #(
  parameter int unsigned WINDOW_MAX  = 256,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rwv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value_i,
  input  logic                                start_series_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rwv_pkg::VOL_W-1:0]           volatility_o,
  output logic                                valid_res_o,
  output logic [rwv_pkg::USED_W-1:0]          samples_used_o
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS + 2 * CNT_W + rwv_pkg::PPY_W;
  localparam int unsigned DIV_W  = (PROD_W > 2 * rwv_pkg::VOL_W) ?
                                   PROD_W : 2 * rwv_pkg::VOL_W + 1;

  rwv_pkg::dp_cmd_t    cmd;
  rwv_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rwv_ctrl #(
    .DIV_W (DIV_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rwv_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIV_W       (DIV_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_value_i (sample_value_i),
    .start_series_i (start_series_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .volatility_o   (volatility_o),
    .valid_res_o    (valid_res_o),
    .samples_used_o (samples_used_o)
  );

endmodule

// ----- hdl/rwv_checker.sv -----
// ----------------------------------------------------------------------------
// rwv_checker
// Port-level checks of the volatility block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwv_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [rwv_pkg::VOL_W-1:0]  volatility_o,
  input logic                       valid_res_o,
  input logic [rwv_pkg::USED_W-1:0] samples_used_o
);

  // A result that is not taken stays offered unchanged.
  `RWV_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(volatility_o))

  // Without two samples the estimate is empty and uses exactly one sample.
  `RWV_ASSERT_IMP(a_single, clk_i, rst_ni, out_valid_o && !valid_res_o, volatility_o == '0 && samples_used_o == rwv_pkg::USED_W'(1))

  // The block works on one item at a time.
  `RWV_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind rolling_window_volatility rwv_checker u_rwv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .volatility_o   (volatility_o),
  .valid_res_o    (valid_res_o),
  .samples_used_o (samples_used_o)
);

// ----- bench/rolling_window_volatility_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rolling_window_volatility_test
// Drives returns into the volatility block under random idling on both
// channels, predicts each annualised standard deviation and checks it.
// ----------------------------------------------------------------------------

class vol_scoreboard;
  logic signed [23:0] ring_q[256];
  int unsigned        wr_pos;
  int unsigned        held;
  int unsigned        win_cfg;
  int unsigned        ppy_cfg;
  logic [26:0]        exp_vol_q[$];
  logic               exp_valid_q[$];
  logic [8:0]         exp_used_q[$];
  int unsigned        errors;

  function new();
    wr_pos = 0;
    held = 0;
    win_cfg = 20;
    ppy_cfg = 252;
    errors = 0;
  endfunction

  function void set_window(int unsigned v);
    win_cfg = v;
  endfunction

  function void set_ppy(int unsigned v);
    ppy_cfg = v;
  endfunction

  function int unsigned pending();
    return exp_vol_q.size();
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function void note_sample(logic signed [23:0] sample, logic restart);
    int unsigned       win;
    int unsigned       n;
    logic signed [63:0] s1;
    logic [63:0]       s2;
    logic [63:0]       mag;
    logic [63:0]       num;
    logic [63:0]       d;
    logic [63:0]       val;
    logic [63:0]       vol;
    logic signed [63:0] s;
    if (restart) begin
      held = 0;
      wr_pos = 0;
    end
    ring_q[wr_pos] = sample;
    wr_pos = (wr_pos + 1) % 256;
    if (held < 256) held++;
    win = win_cfg < 2 ? 2 : (win_cfg > 256 ? 256 : win_cfg);
    n = win < held ? win : held;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < n; i++) begin
      s = ring_q[(wr_pos + 255 - i) % 256];
      mag = s < 0 ? -s : s;
      s1 += s;
      s2 += mag * mag;
    end
    vol = 0;
    if (n >= 2) begin
      mag = s1 < 0 ? -s1 : s1;
      num = n * s2 - mag * mag;
      d = n * (n - 1);
      val = ppy_cfg * (num / d) + (ppy_cfg * (num % d)) / d;
      vol = int_sqrt(val);
      if (vol > 64'd134217727) vol = 64'd134217727;
    end
    exp_vol_q.push_back(vol[26:0]);
    exp_valid_q.push_back(n >= 2);
    exp_used_q.push_back(n[8:0]);
  endfunction

  function void check_result(logic [26:0] vol, logic vres, logic [8:0] used);
    logic [26:0] e_vol;
    logic        e_valid;
    logic [8:0]  e_used;
    if (exp_vol_q.size() == 0) begin
      $display("%0t: unexpected result vol=%0d", $time, vol);
      errors++;
      return;
    end
    e_vol = exp_vol_q.pop_front();
    e_valid = exp_valid_q.pop_front();
    e_used = exp_used_q.pop_front();
    if (vol !== e_vol) begin
      $display("%0t: volatility expected %0d actual %0d", $time, e_vol, vol);
      errors++;
    end
    if (vres !== e_valid) begin
      $display("%0t: valid_res expected %0d actual %0d", $time, e_valid, vres);
      errors++;
    end
    if (used !== e_used) begin
      $display("%0t: samples_used expected %0d actual %0d", $time, e_used, used);
      errors++;
    end
  endfunction
endclass

module rolling_window_volatility_test;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [rwv_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [rwv_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [23:0]                  sample_value_i;
  logic                                start_series_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [rwv_pkg::VOL_W-1:0]           volatility_o;
  logic                                valid_res_o;
  logic [rwv_pkg::USED_W-1:0]          samples_used_o;

  vol_scoreboard vol_sb;
  bit            steady;

  rolling_window_volatility dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_value_i, .start_series_i,
    .out_valid_o, .out_ready_i, .volatility_o, .valid_res_o, .samples_used_o
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 27);
  endfunction

  task automatic write_reg(logic [rwv_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_index_i <= idx;
    cfg_data_i <= value[rwv_pkg::CFG_DATA_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rwv_pkg::CFG_IDX_WINDOW) vol_sb.set_window(value);
    else vol_sb.set_ppy(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    // The next write may only raise valid again at a later edge.
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic signed [23:0] value, logic restart);
    while (idle_now()) @(negedge clk_i);
    sample_value_i <= value;
    start_series_i <= restart;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    vol_sb.note_sample(value, restart);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // The block is busy after taking an item anyway.
    @(negedge clk_i);
  endtask

  // Waits for all results, so the block is idle, then waits on.
  task automatic drain();
    while (vol_sb.pending() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_sample(int unsigned kind);
    case (kind)
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return $signed(24'($urandom_range(2048))) - 24'sd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !idle_now();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      vol_sb.check_result(volatility_o, valid_res_o, samples_used_o);
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned win_set[6];
    int unsigned ppy_set[6];
    vol_sb = new();
    steady = 0;
    cfg_valid_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 0;
    sample_value_i = '0;
    start_series_i = 0;
    out_ready_i = 0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: single sample, extremes, constant series, reset window.
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sd5, 1'b1);
    send_sample(24'sd5, 1'b0);
    send_sample(24'sd0, 1'b0);
    drain();
    write_reg(rwv_pkg::CFG_IDX_WINDOW, 0);
    write_reg(rwv_pkg::CFG_IDX_PPY, 1023);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sd1, 1'b0);
    drain();
    write_reg(rwv_pkg::CFG_IDX_PPY, 0);
    write_reg(rwv_pkg::CFG_IDX_WINDOW, 511);
    send_sample(24'sd123456, 1'b0);
    send_sample(-24'sd654321, 1'b0);
    send_sample(24'sd7, 1'b1);
    drain();
    write_reg(rwv_pkg::CFG_IDX_PPY, 1);
    write_reg(rwv_pkg::CFG_IDX_WINDOW, 1);
    send_sample(24'sh555555, 1'b0);
    send_sample(-24'sh2AAAAB, 1'b0);
    drain();

    win_set = '{2, 256, 20, 3, 300, 64};
    ppy_set = '{1023, 252, 1, 0, 500, 1023};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(rwv_pkg::CFG_IDX_WINDOW, win_set[ph]);
      write_reg(rwv_pkg::CFG_IDX_PPY, ph == 5 ? $urandom_range(1023) : ppy_set[ph]);
      steady = (ph == 2);
      for (int k = 0; k < 250; k++)
        send_sample(rand_sample($urandom_range(9) < 1 ? $urandom_range(1) :
                                $urandom_range(3, 2)), $urandom_range(99) < 2);
      steady = 0;
    end
    while (vol_sb.pending() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (vol_sb.errors == 0 && vol_sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rwv_pkg.sv
hdl/rwv_ctrl.sv
hdl/rwv_datapath.sv
hdl/rolling_window_volatility.sv
hdl/rwv_checker.sv
bench/rolling_window_volatility_test.sv
